// ----- src/fxq8_pkg.sv -----
// Shared types and constants for the fixed-point Q24.8 ALU.
package fxq8_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRACTION_BITS_DEFAULT = 8;

   typedef enum logic [3:0] {
      ACT_ADD      = 4'd0,
      ACT_SUB      = 4'd1,
      ACT_MUL      = 4'd2,
      ACT_DIV      = 4'd3,
      ACT_INC      = 4'd4,
      ACT_DEC      = 4'd5,
      ACT_LT       = 4'd6,
      ACT_GT       = 4'd7,
      ACT_LE       = 4'd8,
      ACT_GE       = 4'd9,
      ACT_EQ       = 4'd10,
      ACT_NE       = 4'd11,
      ACT_MIN      = 4'd12,
      ACT_MAX      = 4'd13,
      ACT_FROM_INT = 4'd14,
      ACT_TO_INT   = 4'd15
   } action_type;

endpackage

// ----- src/fixed_point_q8_alu.sv -----
// Top level of the pipelined signed fixed-point ALU.
//
// Usage:
//   Input channel req_*: one beat carries an action code and two signed raw
//   operands. Result channel rsp_*: one beat per input beat, in order, with
//   the raw result, a comparison flag and a divide-by-zero flag.
//   Every action runs down the same pipeline: an entry stage that decodes the
//   operands and settles every action but multiply and divide, one restoring divide step
//   per stage for 32 + FRACTION_BITS stages (the multiply product is
//   registered in the first of them), and an output register that rounds and
//   saturates multiply and divide results.
//   The pipeline takes one beat per cycle while the receiver does not stall.
//   Reset empties the pipeline; rsp_valid drops on the next cycle.
//   When the receiver stalls, the whole pipeline holds and req_ready falls,
//   so nothing is dropped or repeated; bubbles do not advance alone.
module fixed_point_q8_alu #(
   parameter int FRACTION_BITS = fxq8_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [3:0]                              req_action,
   input  logic signed [fxq8_pkg::DATA_WIDTH-1:0]  req_operand_a,
   input  logic signed [fxq8_pkg::DATA_WIDTH-1:0]  req_operand_b,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [fxq8_pkg::DATA_WIDTH-1:0]  rsp_result_raw,
   output logic                                    rsp_compare_true,
   output logic                                    rsp_divide_by_zero
);
   import fxq8_pkg::*;

   localparam int DW = DATA_WIDTH;
   // quotient width: magnitude shifted up by the fraction bits
   localparam int QW = DW + FRACTION_BITS;
   localparam int PW = 2 * DW;

   typedef struct packed {
      action_type      action;
      logic            neg;
      logic [DW-1:0]   ma;
      logic [DW-1:0]   mb;
      logic [DW-1:0]   rem;
      logic [QW-1:0]   nq;     // numerator bits shifting out, quotient bits in
      logic [PW-1:0]   prod;
      logic [DW-1:0]   res;
      logic            cmp;
   } stage_type;

   stage_type        st_ff    [0:QW];
   stage_type        st_in    [0:QW];
   logic [QW:0]      vld_ff;
   logic [QW:0]      vld_in;
   logic             adv;

   logic [DW-1:0]    rsp_res_ff, rsp_res_in;
   logic             rsp_cmp_ff, rsp_cmp_in;
   logic             rsp_dz_ff,  rsp_dz_in;
   logic             rsp_vld_ff;

   // advance everything while the output register is free or being drained
   assign adv       = !rsp_vld_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------- entry stage: decode, all actions but multiply and divide
   logic [DW-1:0] a_u, b_u, mag_a, mag_b;
   logic          a_lt_b, a_eq_b;

   always_comb begin
      a_u    = req_operand_a;
      b_u    = req_operand_b;
      mag_a  = a_u[DW-1] ? (~a_u + DW'(1)) : a_u;
      mag_b  = b_u[DW-1] ? (~b_u + DW'(1)) : b_u;
      a_lt_b = req_operand_a < req_operand_b;
      a_eq_b = (a_u == b_u);

      st_in[0]        = '0;
      st_in[0].action = action_type'(req_action);
      st_in[0].neg    = a_u[DW-1] ^ b_u[DW-1];
      st_in[0].ma     = mag_a;
      st_in[0].mb     = mag_b;
      st_in[0].nq     = {mag_a, {FRACTION_BITS{1'b0}}};

      unique case (action_type'(req_action))
         ACT_ADD:      st_in[0].res = a_u + b_u;
         ACT_SUB:      st_in[0].res = a_u - b_u;
         ACT_INC:      st_in[0].res = a_u + DW'(1);
         ACT_DEC:      st_in[0].res = a_u - DW'(1);
         ACT_LT:       st_in[0].cmp = a_lt_b;
         ACT_GT:       st_in[0].cmp = !a_lt_b && !a_eq_b;
         ACT_LE:       st_in[0].cmp = a_lt_b || a_eq_b;
         ACT_GE:       st_in[0].cmp = !a_lt_b;
         ACT_EQ:       st_in[0].cmp = a_eq_b;
         ACT_NE:       st_in[0].cmp = !a_eq_b;
         ACT_MIN:      st_in[0].res = a_lt_b ? a_u : b_u;
         ACT_MAX:      st_in[0].res = (!a_lt_b && !a_eq_b) ? a_u : b_u;
         ACT_FROM_INT: st_in[0].res = a_u << FRACTION_BITS;
         ACT_TO_INT:   st_in[0].res = DW'(req_operand_a >>> FRACTION_BITS);
         default:      st_in[0].res = '0;   // multiply and divide finish later
      endcase
   end

   assign vld_in[0] = req_valid;

   // ---------------- divide steps, one quotient bit per stage --------------
   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [DW:0] trial;
      logic        ge;

      always_comb begin
         trial        = {st_ff[k].rem, st_ff[k].nq[QW-1]};
         ge           = trial >= {1'b0, st_ff[k].mb};
         st_in[k+1]   = st_ff[k];
         st_in[k+1].rem = ge ? DW'(trial - {1'b0, st_ff[k].mb}) : DW'(trial);
         st_in[k+1].nq  = {st_ff[k].nq[QW-2:0], ge};
         // the product is formed once, in the first step
         if (k == 0) begin
            st_in[k+1].prod = st_ff[k].ma * st_ff[k].mb;
         end
      end

      assign vld_in[k+1] = vld_ff[k];
   end

   for (genvar s = 0; s <= QW; s++) begin : g_reg
      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- output stage: round, saturate, select -----------------
   logic [PW-1:0] mul_mag, div_mag, mag;
   logic          round_up;
   logic [DW-1:0] sat_res;
   stage_type     last;

   always_comb begin
      last     = st_ff[QW];
      mul_mag  = (last.prod + (PW'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
      round_up = {last.rem, 1'b0} >= {1'b0, last.mb};
      div_mag  = PW'({1'b0, last.nq}) + PW'(round_up);
      mag      = (last.action == ACT_MUL) ? mul_mag : div_mag;

      if (last.neg) begin
         sat_res = (mag >= (PW'(1) << (DW - 1))) ? {1'b1, {(DW-1){1'b0}}}
                                                 : (~mag[DW-1:0] + DW'(1));
      end else begin
         sat_res = (mag > PW'({1'b0, {(DW-1){1'b1}}})) ? {1'b0, {(DW-1){1'b1}}}
                                                      : mag[DW-1:0];
      end

      rsp_res_in = last.res;
      rsp_cmp_in = last.cmp;
      rsp_dz_in  = 1'b0;
      priority if (last.action == ACT_DIV && last.mb == '0) begin
         rsp_res_in = '0;
         rsp_dz_in  = 1'b1;
      end else if (last.action == ACT_DIV || last.action == ACT_MUL) begin
         rsp_res_in = sat_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_res_ff <= rsp_res_in;
         rsp_cmp_ff <= rsp_cmp_in;
         rsp_dz_ff  <= rsp_dz_in;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_result_raw     = rsp_res_ff;
   assign rsp_compare_true   = rsp_cmp_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

   // ---------------- checks ----------------
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_result_raw == '0)
      else $error("divide by zero with nonzero result");

   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |-> rsp_result_raw == '0)
      else $error("comparison with nonzero result");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_compare_true && rsp_divide_by_zero))
      else $error("both flags set");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

endmodule

// ----- sim/fixed_point_q8_alu_test.sv -----
// Self-checking testbench for the pipelined Q24.8 fixed-point ALU.
`timescale 1ns / 100ps

module fixed_point_q8_alu_test;
   import fxq8_pkg::*;

   localparam int FRAC      = 8;
   localparam int LATENCY   = FRAC + 34;
   localparam int WATCHDOG  = 20000;
   localparam int N_RANDOM  = 1500;

   typedef struct packed {
      logic [3:0]  action;
      logic [31:0] op_a;
      logic [31:0] op_b;
   } alu_beat_type;

   typedef struct packed {
      logic [31:0] result;
      logic        cmp;
      logic        dz;
   } alu_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_action = 4'd0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [31:0] rsp_result_raw;
   logic        rsp_compare_true;
   logic        rsp_divide_by_zero;

   alu_beat_type   pending_beats[$];
   alu_result_type expected_results[$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          beats_sent = 0;
   int          beats_checked = 0;
   bit          req_taken = 1'b0;    // input beat accepted at the last rising edge
   bit          drain_hold = 1'b0;   // sender holds off until the pipe is empty
   int          send_gap = 0;
   int          recv_gap = 0;

   fixed_point_q8_alu u_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] abs_mag(logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;   // 0x80000000 maps to itself
   endfunction

   function automatic logic [31:0] clamp_signed(logic [63:0] mag, logic neg);
      if (neg) begin
         if (mag >= 64'h8000_0000) return 32'h8000_0000;
         return ~mag[31:0] + 32'd1;
      end
      if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return mag[31:0];
   endfunction

   // Compute what the ALU returns for one beat.
   function automatic alu_result_type alu_predict(alu_beat_type b);
      alu_result_type r;
      logic signed [31:0] sa, sb;
      logic [63:0] ma, mb, prod, num, quo;
      logic neg;
      sa = b.op_a;
      sb = b.op_b;
      ma = {32'd0, abs_mag(b.op_a)};
      mb = {32'd0, abs_mag(b.op_b)};
      neg = b.op_a[31] ^ b.op_b[31];
      r = '0;
      case (action_type'(b.action))
         ACT_ADD: r.result = b.op_a + b.op_b;
         ACT_SUB: r.result = b.op_a - b.op_b;
         ACT_MUL: begin
            prod = ma * mb;
            r.result = clamp_signed((prod + (64'd1 << (FRAC - 1))) >> FRAC, neg);
         end
         ACT_DIV: begin
            if (mb == 0) begin
               r.dz = 1'b1;
            end else begin
               num = ma << FRAC;
               quo = (2 * num + mb) / (2 * mb);
               r.result = clamp_signed(quo, neg);
            end
         end
         ACT_INC: r.result = b.op_a + 32'd1;
         ACT_DEC: r.result = b.op_a - 32'd1;
         ACT_LT:  r.cmp = sa < sb;
         ACT_GT:  r.cmp = sa > sb;
         ACT_LE:  r.cmp = sa <= sb;
         ACT_GE:  r.cmp = sa >= sb;
         ACT_EQ:  r.cmp = sa == sb;
         ACT_NE:  r.cmp = sa != sb;
         ACT_MIN: r.result = (sa < sb) ? b.op_a : b.op_b;
         ACT_MAX: r.result = (sa > sb) ? b.op_a : b.op_b;
         ACT_FROM_INT: r.result = b.op_a << FRAC;
         default: r.result = sa >>> FRAC;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return {24'd0, 8'($urandom)};           // small fractions
         3: return {{20{1'b1}}, 12'($urandom)};     // small negatives
         4: return 32'd0;
         5: return {16'(($urandom & 1) ? '1 : '0), 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic alu_beat_type make_beat(action_type act, logic [31:0] a,
                                              logic [31:0] b);
      alu_beat_type t;
      t.action = act;
      t.op_a = a;
      t.op_b = b;
      return t;
   endfunction

   // Driver: change inputs on the falling edge, hold a beat until accepted.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0 && !drain_hold) begin
               alu_beat_type t;
               t = pending_beats.pop_front();
               req_action <= t.action;
               req_operand_a <= t.op_a;
               req_operand_b <= t.op_b;
               req_valid <= 1'b1;
               send_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) recv_gap <= pick_gap();
         end
      end
   end

   // Monitor: sample at the rising edge; log accepted inputs, check results.
   always @(posedge clock) begin
      if (!reset) begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            expected_results.push_back(alu_predict(make_beat(
               action_type'(req_action), req_operand_a, req_operand_b)));
            beats_sent <= beats_sent + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat raw=%h", $time, rsp_result_raw);
               errors <= errors + 1;
            end else begin
               alu_result_type e;
               e = expected_results.pop_front();
               if (e.result !== rsp_result_raw || e.cmp !== rsp_compare_true ||
                   e.dz !== rsp_divide_by_zero) begin
                  $display("%0t: mismatch expected raw=%h cmp=%b dz=%b actual raw=%h cmp=%b dz=%b",
                     $time, e.result, e.cmp, e.dz,
                     rsp_result_raw, rsp_compare_true, rsp_divide_by_zero);
                  errors <= errors + 1;
               end
            end
            beats_checked <= beats_checked + 1;
         end
         // Watchdog: count cycles with no beat on either channel.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG) begin
            $display("%0t: watchdog expired", $time);
            $display("Regression FAIL");
            $finish;
         end else if (pending_beats.size() > 0 || expected_results.size() > 0 ||
                      req_valid) begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      alu_beat_type t;
      int k;
      // Directed beats: extremes, every action, zero divisor, overflow, ties.
      pending_beats.push_back(make_beat(ACT_ADD, 32'h7FFF_FFFF, 32'd1));
      pending_beats.push_back(make_beat(ACT_SUB, 32'h8000_0000, 32'd1));
      pending_beats.push_back(make_beat(ACT_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pending_beats.push_back(make_beat(ACT_MUL, 32'h8000_0000, 32'h0000_0100));
      pending_beats.push_back(make_beat(ACT_MUL, 32'h8000_0000, 32'h8000_0000));
      pending_beats.push_back(make_beat(ACT_MUL, 32'h0000_0080, 32'h0000_0001));
      pending_beats.push_back(make_beat(ACT_MUL, 32'hFFFF_FF80, 32'h0000_0001));
      pending_beats.push_back(make_beat(ACT_DIV, 32'h0000_0100, 32'd0));
      pending_beats.push_back(make_beat(ACT_DIV, 32'h7FFF_FFFF, 32'd1));
      pending_beats.push_back(make_beat(ACT_DIV, 32'h8000_0000, 32'hFFFF_FFFF));
      pending_beats.push_back(make_beat(ACT_DIV, 32'd1, 32'h0000_0200));
      pending_beats.push_back(make_beat(ACT_DIV, 32'hFFFF_FFFF, 32'h0000_0200));
      pending_beats.push_back(make_beat(ACT_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      pending_beats.push_back(make_beat(ACT_DEC, 32'h8000_0000, 32'hFFFF_FFFF));
      pending_beats.push_back(make_beat(ACT_LT, 32'h8000_0000, 32'h7FFF_FFFF));
      pending_beats.push_back(make_beat(ACT_GT, 32'h8000_0000, 32'h7FFF_FFFF));
      pending_beats.push_back(make_beat(ACT_LE, 32'h1234_5678, 32'h1234_5678));
      pending_beats.push_back(make_beat(ACT_GE, 32'hFFFF_FFFF, 32'd0));
      pending_beats.push_back(make_beat(ACT_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_beats.push_back(make_beat(ACT_NE, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
      pending_beats.push_back(make_beat(ACT_MIN, 32'h0000_0500, 32'h0000_0500));
      pending_beats.push_back(make_beat(ACT_MAX, 32'h8000_0000, 32'h7FFF_FFFF));
      pending_beats.push_back(make_beat(ACT_FROM_INT, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      pending_beats.push_back(make_beat(ACT_TO_INT, 32'hFFFF_FF01, 32'h0));
      pending_beats.push_back(make_beat(ACT_TO_INT, 32'h7FFF_FFFF, 32'hFFFF_FFFF));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Hold the sender until the directed part has drained completely.
      wait (pending_beats.size() == 0);
      drain_hold = 1'b1;
      wait (expected_results.size() == 0 && !req_valid);
      repeat (LATENCY) @(posedge clock);
      drain_hold = 1'b0;

      // Random beats, all queued up front for the sender to drain.
      for (k = 0; k < N_RANDOM; k++) begin
         t.action = 4'($urandom_range(0, 15));
         t.op_a = rand_operand();
         t.op_b = ($urandom_range(0, 19) == 0) ? 32'd0 : rand_operand();
         pending_beats.push_back(t);
      end

      wait (pending_beats.size() == 0);
      @(posedge clock);
      wait (!req_valid);
      wait (expected_results.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);

      $display("Covered %0d beats over all 16 actions, with random stalls on both channels.",
               beats_sent);
      $display("Checked %0d result beats, %0d mismatches.", beats_checked, errors);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/fxq8_pkg.sv
src/fixed_point_q8_alu.sv
sim/fixed_point_q8_alu_test.sv
